/* sv/rch_pkg.sv */
// Shared types and constants for the RGB component histogram.
package rch_pkg;

    localparam int unsigned MAX_PIXELS = 1048576;
    localparam int unsigned NUM_BINS   = 256;
    localparam int unsigned BIN_W      = $clog2(NUM_BINS);
    localparam int unsigned COUNT_W    = 22;

    localparam longint unsigned COUNT_MASK = (64'd1 << COUNT_W) - 64'd1;
    localparam longint unsigned RAW_LIMIT  = 64'd3 * MAX_PIXELS;
    localparam logic [COUNT_W-1:0] BIN_LIMIT =
        COUNT_W'((RAW_LIMIT > COUNT_MASK) ? COUNT_MASK : RAW_LIMIT);

    // Command queue between front and back
    localparam int unsigned QUEUE_DEPTH = 4;
    localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);

    typedef enum logic {
        FUNC_ACCUM = 1'b0,
        FUNC_READ  = 1'b1
    } func_t;

    // One queued command; a read keeps its bin in slot 0.
    typedef struct packed {
        func_t            func;
        logic [BIN_W-1:0] bin0;
        logic [BIN_W-1:0] bin1;
        logic [BIN_W-1:0] bin2;
    } op_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_FETCH,
        ST_UPDATE
    } back_state_t;

endpackage

/* sv/rch_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module rch_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

/* sv/rch_front.sv */
// Front end: takes input beats, decodes them into commands and queues them.
module rch_front
    import rch_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic             func,
    input  logic [7:0]       red,
    input  logic [7:0]       green,
    input  logic [7:0]       blue,
    input  logic [7:0]       bin_index,
    output logic             q_valid,
    input  logic             q_ready,
    output op_t              q_op
);

    op_t               entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QPTR_W:0]   fill_reg, fill_next;
    op_t               new_op;
    logic              push, pop;

    always_comb
    begin
        new_op.func = func_t'(func);
        if (func_t'(func) == FUNC_READ)
        begin
            new_op.bin0 = bin_index;
            new_op.bin1 = '0;
            new_op.bin2 = '0;
        end
        else
        begin
            new_op.bin0 = red;
            new_op.bin1 = green;
            new_op.bin2 = blue;
        end
    end

    assign in_ready = (fill_reg != (QPTR_W+1)'(QUEUE_DEPTH));
    assign q_valid  = (fill_reg != '0);
    assign q_op     = entry_reg[rd_ptr_reg];
    assign push     = in_valid && in_ready;
    assign pop      = q_valid && q_ready;

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop  ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        fill_next   = fill_reg;
        if (push && !pop)
        begin
            fill_next = fill_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            fill_next = fill_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= new_op;
        end
    end

endmodule

/* sv/rch_back.sv */
// Back end: read-modify-write sequencer over the bin store, plus the result register.
module rch_back
    import rch_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               q_valid,
    output logic               q_ready,
    input  op_t                q_op,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [BIN_W-1:0]   bin_echo,
    output logic [COUNT_W-1:0] bin_count,
    output logic               bin_nonzero
);

    back_state_t        state_reg, state_next;
    op_t                op_reg, op_next;
    logic [1:0]         comp_reg, comp_next;
    logic [NUM_BINS-1:0] valid_reg, valid_next;

    logic               out_valid_reg, out_valid_next;
    logic [BIN_W-1:0]   echo_reg, echo_next;
    logic [COUNT_W-1:0] count_reg, count_next;
    logic               nonzero_reg, nonzero_next;

    logic [BIN_W-1:0]   cur_bin;
    logic [COUNT_W-1:0] ram_rdata, cur_count;
    logic [COUNT_W-1:0] wr_data;
    logic               wr_en;
    logic               out_free;

    always_comb
    begin
        case (comp_reg)
            2'd0:    cur_bin = op_reg.bin0;
            2'd1:    cur_bin = op_reg.bin1;
            default: cur_bin = op_reg.bin2;
        endcase
    end

    // Bins never written since reset read as zero
    assign cur_count = valid_reg[cur_bin] ? ram_rdata : '0;
    assign out_free  = !out_valid_reg || out_ready;

    rch_ram #(
        .WIDTH(COUNT_W),
        .DEPTH(NUM_BINS)
    ) u_store (
        .clk  (clk),
        .we   (wr_en),
        .waddr(cur_bin),
        .wdata(wr_data),
        .raddr(cur_bin),
        .rdata(ram_rdata)
    );

    always_comb
    begin
        state_next     = state_reg;
        op_next        = op_reg;
        comp_next      = comp_reg;
        valid_next     = valid_reg;
        out_valid_next = out_valid_reg && !out_ready;
        echo_next      = echo_reg;
        count_next     = count_reg;
        nonzero_next   = nonzero_reg;
        q_ready        = 1'b0;
        wr_en          = 1'b0;
        wr_data        = (cur_count < BIN_LIMIT) ? cur_count + 1'b1 : cur_count;

        case (state_reg)
            ST_IDLE:
            begin
                q_ready = 1'b1;
                if (q_valid)
                begin
                    op_next    = q_op;
                    comp_next  = 2'd0;
                    state_next = ST_FETCH;
                end
            end
            ST_FETCH:
            begin
                state_next = ST_UPDATE;
            end
            ST_UPDATE:
            begin
                if (op_reg.func == FUNC_READ)
                begin
                    // clearing is just dropping the valid bit
                    if (out_free)
                    begin
                        out_valid_next      = 1'b1;
                        echo_next           = cur_bin;
                        count_next          = cur_count;
                        nonzero_next        = (cur_count != '0);
                        valid_next[cur_bin] = 1'b0;
                        state_next          = ST_IDLE;
                    end
                end
                else
                begin
                    wr_en               = 1'b1;
                    valid_next[cur_bin] = 1'b1;
                    if (comp_reg == 2'd2)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        comp_next  = comp_reg + 1'b1;
                        state_next = ST_FETCH;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            comp_reg      <= '0;
            valid_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            comp_reg      <= comp_next;
            valid_reg     <= valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg      <= op_next;
        echo_reg    <= echo_next;
        count_reg   <= count_next;
        nonzero_reg <= nonzero_next;
    end

    assign out_valid   = out_valid_reg;
    assign bin_echo    = echo_reg;
    assign bin_count   = count_reg;
    assign bin_nonzero = nonzero_reg;

endmodule

/* sv/rgb_component_histogram_unit.sv */
// Top level of the RGB component histogram: command queue front end and bin store back end.
//
// 256 saturating 22-bit bin counters over 8-bit color values. An accumulate
// beat (func 0) adds one to the bins of red, green and blue in turn; a read
// beat (func 1) returns one bin's count and nonzero flag and clears the bin.
// Beats land in a 4-deep command queue, so the input side keeps accepting while the
// back end works, until the queue is full. The back end does one read-modify-write
// per component through a single-port-pair RAM with registered read: a fetch state
// and an update state per component, then the idle state picks up the next command.
// A read waits in its update state while the result register is still occupied.
// The store needs no clearing pass: per-bin valid bits reset to zero at once.
module rgb_component_histogram_unit
    import rch_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        func,
    input  logic [7:0]  red,
    input  logic [7:0]  green,
    input  logic [7:0]  blue,
    input  logic [7:0]  bin_index,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [7:0]  bin_echo,
    output logic [21:0] bin_count,
    output logic        bin_nonzero
);

    logic q_valid;
    logic q_ready;
    op_t  q_op;

    rch_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .func     (func),
        .red      (red),
        .green    (green),
        .blue     (blue),
        .bin_index(bin_index),
        .q_valid  (q_valid),
        .q_ready  (q_ready),
        .q_op     (q_op)
    );

    rch_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_valid    (q_valid),
        .q_ready    (q_ready),
        .q_op       (q_op),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .bin_echo   (bin_echo),
        .bin_count  (bin_count),
        .bin_nonzero(bin_nonzero)
    );

endmodule
